FILE: design/urb_pkg.sv
// shared types, codes and helpers for the uart register block
`timescale 1ns / 1ps
package urb_pkg;

  localparam int FIFO_DEPTH_DEF = 16;
  localparam int DLAB_BIT       = 7;
  localparam int OUT2_BIT       = 3;

  typedef enum logic [1:0] {
    OP_BUS_READ  = 2'd0,
    OP_BUS_WRITE = 2'd1,
    OP_LINE_RX   = 2'd2,
    OP_LINE_TX   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    REG_DATA = 3'd0,
    REG_IER  = 3'd1,
    REG_IIR  = 3'd2,
    REG_LCR  = 3'd3,
    REG_MCR  = 3'd4,
    REG_LSR  = 3'd5,
    REG_MSR  = 3'd6,
    REG_SCR  = 3'd7
  } reg_addr_t;

  localparam logic [3:0] IIR_NONE   = 4'h1;
  localparam logic [3:0] IIR_LINE   = 4'h6;
  localparam logic [3:0] IIR_RXDATA = 4'h4;
  localparam logic [3:0] IIR_THRE   = 4'h2;
  localparam logic [3:0] IIR_MODEM  = 4'h0;

  localparam logic [1:0] IIR_FIFO_ON = 2'b11;

  typedef struct packed {
    opcode_t     opcode;
    reg_addr_t   reg_addr;
    logic [7:0]  write_data;
    logic [7:0]  rx_byte;
    logic        rx_parity_error;
    logic        rx_framing_error;
    logic        rx_break;
    logic        cts_in;
    logic        dsr_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq;
    logic        rts_out;
    logic        dtr_out;
    logic [15:0] baud_divisor;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clr;
  } fifo_ctl_t;

  // interrupt identification in priority order
  function automatic logic [3:0] iir_code(input logic [3:0] ier, input logic line_pend,
                                          input logic rx_pend, input logic thre_pend,
                                          input logic modem_pend);
    logic [3:0] code;
    code = IIR_NONE;
    if (ier[2] && line_pend) begin
      code = IIR_LINE;
    end else if (ier[0] && rx_pend) begin
      code = IIR_RXDATA;
    end else if (ier[1] && thre_pend) begin
      code = IIR_THRE;
    end else if (ier[3] && modem_pend) begin
      code = IIR_MODEM;
    end
    return code;
  endfunction

endpackage

FILE: design/urb_chan_if.sv
// valid/ready channel carrying one payload item per transfer
`timescale 1ns / 1ps
interface urb_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/urb_fifo.sv
// fifo with registered head read, used for receive entries and transmit bytes
`timescale 1ns / 1ps
module urb_fifo #(
  parameter int DEPTH = urb_pkg::FIFO_DEPTH_DEF,
  parameter int WIDTH = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  urb_pkg::fifo_ctl_t           ctl,
  input  logic [WIDTH-1:0]             wdata,
  output logic [WIDTH-1:0]             head,
  output logic [$clog2(DEPTH+1)-1:0]   fill
);
  import urb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] head_r;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             push_en;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign push_en = ctl.push && !ctl.clr;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    fill_nxt   = fill_r;
    if (ctl.clr) begin
      rd_ptr_nxt = '0;
      wr_ptr_nxt = '0;
      fill_nxt   = '0;
    end else begin
      if (ctl.push) begin
        wr_ptr_nxt = ptr_inc(wr_ptr_r);
      end
      if (ctl.pop) begin
        rd_ptr_nxt = ptr_inc(rd_ptr_r);
      end
      if (ctl.push && !ctl.pop) begin
        fill_nxt = fill_r + CNT_W'(1);
      end else if (ctl.pop && !ctl.push) begin
        fill_nxt = fill_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // head read follows the next read pointer, with write bypass
  always_ff @(posedge clk) begin
    if (push_en && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= wdata;
    end else begin
      head_r <= mem_r[rd_ptr_nxt];
    end
  end

  assign head = head_r;
  assign fill = fill_r;

endmodule

FILE: design/uart_16550_register_block.sv
// 16550-style uart register file with receive and transmit fifos
// One bus access or line event is taken per cycle, with the result held in the output register
// from the cycle after its transfer; a new item is taken whenever the output register is
// empty or being emptied. irq, rts_out, dtr_out and baud_divisor show the register state
// after the last transferred item. Each fifo is a single-port-write memory whose head entry
// is read into a register every cycle, so pops and pushes run at full rate. No clearing pass
// is needed after reset; fifo contents are only read inside the fill count.
`timescale 1ns / 1ps
module uart_16550_register_block #(
  parameter int FIFO_DEPTH = urb_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  urb_chan_if.sink    in_ch,
  urb_chan_if.source  out_ch
);
  import urb_pkg::*;

  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int RX_W  = 11;

  in_item_t         d;
  out_item_t        res;
  logic             accept;

  logic [3:0]       ier_r, ier_nxt;
  logic [7:0]       lcr_r, lcr_nxt;
  logic [4:0]       mcr_r, mcr_nxt;
  logic [7:0]       scr_r, scr_nxt;
  logic [15:0]      div_r, div_nxt;
  logic             fifo_mode_r, fifo_mode_nxt;
  logic             overrun_r, overrun_nxt;
  logic             cts_r, dsr_r;
  logic             dcts_r, dcts_nxt;
  logic             ddsr_r, ddsr_nxt;
  logic [CNT_W-1:0] rx_err_cnt_r, rx_err_cnt_nxt;

  logic             out_valid_r;
  logic [7:0]       rd_data_r, rd_data_nxt;
  logic             tx_valid_r, tx_valid_nxt;
  logic [7:0]       tx_byte_r, tx_byte_nxt;

  fifo_ctl_t        rx_ctl, tx_ctl;
  logic [RX_W-1:0]  rx_head, rx_wdata;
  logic [7:0]       tx_head, tx_wdata;
  logic [CNT_W-1:0] rx_fill, tx_fill, cap;

  logic             dlab, dcts_s, ddsr_s;
  logic [2:0]       rx_head_err;
  logic             rx_new_err, en_bit, mode_chg;
  logic [3:0]       iir_now, iir_post;
  logic [7:0]       lsr_now;

  urb_fifo #(.DEPTH(FIFO_DEPTH), .WIDTH(RX_W)) u_rx_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (rx_ctl),
    .wdata (rx_wdata),
    .head  (rx_head),
    .fill  (rx_fill)
  );

  urb_fifo #(.DEPTH(FIFO_DEPTH), .WIDTH(8)) u_tx_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (tx_ctl),
    .wdata (tx_wdata),
    .head  (tx_head),
    .fill  (tx_fill)
  );

  assign d           = in_ch.data;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // state as seen at the start of the step
  assign dlab        = lcr_r[DLAB_BIT];
  assign cap         = fifo_mode_r ? CNT_W'(FIFO_DEPTH) : CNT_W'(1);
  assign dcts_s      = dcts_r || (d.cts_in != cts_r);
  assign ddsr_s      = ddsr_r || (d.dsr_in != dsr_r);
  assign rx_head_err = (rx_fill != '0) ? rx_head[10:8] : 3'b000;
  assign rx_new_err  = d.rx_parity_error || d.rx_framing_error || d.rx_break;
  assign rx_wdata    = {d.rx_break, d.rx_framing_error, d.rx_parity_error, d.rx_byte};
  assign tx_wdata    = d.write_data;
  assign en_bit      = d.write_data[0];
  assign mode_chg    = en_bit != fifo_mode_r;

  assign iir_now = iir_code(ier_r, overrun_r || (rx_head_err != 3'b000), rx_fill != '0,
                            tx_fill == '0, dcts_s || ddsr_s);

  always_comb begin
    lsr_now      = 8'h00;
    lsr_now[0]   = rx_fill != '0;
    lsr_now[1]   = overrun_r;
    lsr_now[4:2] = rx_head_err;
    lsr_now[5]   = tx_fill == '0;
    lsr_now[6]   = tx_fill == '0;
    lsr_now[7]   = fifo_mode_r && (rx_err_cnt_r != '0);
  end

  always_comb begin
    ier_nxt        = ier_r;
    lcr_nxt        = lcr_r;
    mcr_nxt        = mcr_r;
    scr_nxt        = scr_r;
    div_nxt        = div_r;
    fifo_mode_nxt  = fifo_mode_r;
    overrun_nxt    = overrun_r;
    dcts_nxt       = dcts_s;
    ddsr_nxt       = ddsr_s;
    rx_err_cnt_nxt = rx_err_cnt_r;
    rx_ctl         = '0;
    tx_ctl         = '0;
    rd_data_nxt    = 8'h00;
    tx_valid_nxt   = 1'b0;
    tx_byte_nxt    = 8'h00;

    unique case (d.opcode)
      OP_BUS_READ: begin
        unique case (d.reg_addr)
          REG_DATA: begin
            if (dlab) begin
              rd_data_nxt = div_r[7:0];
            end else if (rx_fill != '0) begin
              rd_data_nxt = rx_head[7:0];
              rx_ctl.pop  = 1'b1;
              if (rx_head_err != 3'b000) begin
                rx_err_cnt_nxt = rx_err_cnt_r - CNT_W'(1);
              end
            end
          end
          REG_IER: rd_data_nxt = dlab ? div_r[15:8] : {4'h0, ier_r};
          REG_IIR: rd_data_nxt = {fifo_mode_r ? IIR_FIFO_ON : 2'b00, 2'b00, iir_now};
          REG_LCR: rd_data_nxt = lcr_r;
          REG_MCR: rd_data_nxt = {3'b000, mcr_r};
          REG_LSR: begin
            rd_data_nxt = lsr_now;
            overrun_nxt = 1'b0;
          end
          REG_MSR: begin
            rd_data_nxt = {2'b00, d.dsr_in, d.cts_in, 2'b00, ddsr_s, dcts_s};
            dcts_nxt    = 1'b0;
            ddsr_nxt    = 1'b0;
          end
          REG_SCR: rd_data_nxt = scr_r;
        endcase
      end
      OP_BUS_WRITE: begin
        unique case (d.reg_addr)
          REG_DATA: begin
            if (dlab) begin
              div_nxt[7:0] = d.write_data;
            end else if (tx_fill < cap) begin
              tx_ctl.push = 1'b1;
            end
          end
          REG_IER: begin
            if (dlab) begin
              div_nxt[15:8] = d.write_data;
            end else begin
              ier_nxt = d.write_data[3:0];
            end
          end
          REG_IIR: begin
            if (mode_chg || (en_bit && d.write_data[1])) begin
              rx_ctl.clr     = 1'b1;
              rx_err_cnt_nxt = '0;
            end
            if (mode_chg || (en_bit && d.write_data[2])) begin
              tx_ctl.clr = 1'b1;
            end
            fifo_mode_nxt = en_bit;
          end
          REG_LCR: lcr_nxt = d.write_data;
          REG_MCR: mcr_nxt = d.write_data[4:0];
          REG_LSR: ;
          REG_MSR: ;
          REG_SCR: scr_nxt = d.write_data;
        endcase
      end
      OP_LINE_RX: begin
        if (rx_fill >= cap) begin
          overrun_nxt = 1'b1;
        end else begin
          rx_ctl.push = 1'b1;
          if (rx_new_err) begin
            rx_err_cnt_nxt = rx_err_cnt_r + CNT_W'(1);
          end
        end
      end
      OP_LINE_TX: begin
        if (tx_fill != '0) begin
          tx_valid_nxt = 1'b1;
          tx_byte_nxt  = tx_head;
          tx_ctl.pop   = 1'b1;
        end
      end
    endcase

    if (!accept) begin
      rx_ctl = '0;
      tx_ctl = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ier_r        <= '0;
      lcr_r        <= '0;
      mcr_r        <= '0;
      scr_r        <= '0;
      div_r        <= '0;
      fifo_mode_r  <= 1'b0;
      overrun_r    <= 1'b0;
      cts_r        <= 1'b0;
      dsr_r        <= 1'b0;
      dcts_r       <= 1'b0;
      ddsr_r       <= 1'b0;
      rx_err_cnt_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        ier_r        <= ier_nxt;
        lcr_r        <= lcr_nxt;
        mcr_r        <= mcr_nxt;
        scr_r        <= scr_nxt;
        div_r        <= div_nxt;
        fifo_mode_r  <= fifo_mode_nxt;
        overrun_r    <= overrun_nxt;
        cts_r        <= d.cts_in;
        dsr_r        <= d.dsr_in;
        dcts_r       <= dcts_nxt;
        ddsr_r       <= ddsr_nxt;
        rx_err_cnt_r <= rx_err_cnt_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r  <= rd_data_nxt;
      tx_valid_r <= tx_valid_nxt;
      tx_byte_r  <= tx_byte_nxt;
    end
  end

  // interrupt from the state left by the last transfer
  assign iir_post = iir_code(ier_r, overrun_r || ((rx_fill != '0) && (rx_head[10:8] != 3'b000)),
                             rx_fill != '0, tx_fill == '0, dcts_r || ddsr_r);

  always_comb begin
    res.read_data    = rd_data_r;
    res.tx_valid     = tx_valid_r;
    res.tx_byte      = tx_byte_r;
    res.irq          = mcr_r[OUT2_BIT] && (iir_post != IIR_NONE);
    res.rts_out      = mcr_r[1];
    res.dtr_out      = mcr_r[0];
    res.baud_divisor = div_r;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = res;

endmodule

FILE: sim/uart_16550_register_block_tb.sv
// testbench for uart_16550_register_block: directed and random bus and line traffic
`timescale 1ns / 1ps
module uart_16550_register_block_tb;
  import urb_pkg::*;

  localparam int DEPTH        = FIFO_DEPTH_DEF;
  localparam int MAX_WAIT     = 12;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int MAX_REPORTS  = 10;

  localparam logic [7:0] LSR_THRE     = 8'h20;
  localparam logic [7:0] LSR_TEMT     = 8'h40;
  localparam logic [7:0] LSR_FIFO_ERR = 8'h80;

  logic clk;
  logic rst_n;

  urb_chan_if #(.T(in_item_t))  in_if ();
  urb_chan_if #(.T(out_item_t)) out_if ();

  uart_16550_register_block #(.FIFO_DEPTH(DEPTH)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // uart state as seen by the driver
  logic [10:0] rx_fifo [DEPTH];
  logic [7:0]  tx_fifo [DEPTH];
  int          rx_head, rx_used, tx_head, tx_count;
  logic [15:0] divisor;
  logic [7:0]  ier_q, lcr_q, mcr_q, scr_q;
  bit          fifo_on, overrun;
  bit          cts_q, dsr_q, delta_cts, delta_dsr;

  out_item_t   uart_response_q [$];
  int          mismatches = 0;
  int unsigned cycle_count = 0;
  bit          steady_flow = 1'b0;
  bit          line_cts = 1'b0;
  bit          line_dsr = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("uart_16550_register_block verification failed");
      $finish;
    end
  end

  function automatic void clear_uart_state();
    rx_head = 0;
    rx_used = 0;
    tx_head = 0;
    tx_count = 0;
    divisor = '0;
    ier_q = '0;
    lcr_q = '0;
    mcr_q = '0;
    scr_q = '0;
    fifo_on = 1'b0;
    overrun = 1'b0;
    cts_q = 1'b0;
    dsr_q = 1'b0;
    delta_cts = 1'b0;
    delta_dsr = 1'b0;
  endfunction

  function automatic int fifo_capacity();
    return fifo_on ? DEPTH : 1;
  endfunction

  function automatic logic [2:0] rx_head_flags();
    return (rx_used == 0) ? 3'b000 : rx_fifo[rx_head][10:8];
  endfunction

  function automatic logic [3:0] pending_irq_id();
    if (ier_q[2] && (overrun || rx_head_flags() != 3'b000)) return IIR_LINE;
    if (ier_q[0] && rx_used > 0) return IIR_RXDATA;
    if (ier_q[1] && tx_count == 0) return IIR_THRE;
    if (ier_q[3] && (delta_cts || delta_dsr)) return IIR_MODEM;
    return IIR_NONE;
  endfunction

  function automatic logic [7:0] line_status();
    logic [7:0] v;
    v = {3'b000, rx_head_flags(), overrun, rx_used > 0};
    if (tx_count == 0) v |= LSR_THRE | LSR_TEMT;
    if (fifo_on) begin
      for (int i = 0; i < rx_used; i++) begin
        if (rx_fifo[(rx_head + i) % DEPTH][10:8] != 3'b000) v |= LSR_FIFO_ERR;
      end
    end
    return v;
  endfunction

  function automatic logic [7:0] bus_read(reg_addr_t a);
    logic [7:0] v;
    v = 8'h00;
    case (a)
      REG_DATA: begin
        if (lcr_q[DLAB_BIT]) begin
          v = divisor[7:0];
        end else if (rx_used > 0) begin
          v = rx_fifo[rx_head][7:0];
          rx_head = (rx_head + 1) % DEPTH;
          rx_used--;
        end
      end
      REG_IER: v = lcr_q[DLAB_BIT] ? divisor[15:8] : ier_q;
      REG_IIR: v = {(fifo_on ? IIR_FIFO_ON : 2'b00), 2'b00, pending_irq_id()};
      REG_LCR: v = lcr_q;
      REG_MCR: v = mcr_q;
      REG_LSR: begin
        v = line_status();
        overrun = 1'b0;
      end
      REG_MSR: begin
        v = {2'b00, dsr_q, cts_q, 2'b00, delta_dsr, delta_cts};
        delta_cts = 1'b0;
        delta_dsr = 1'b0;
      end
      default: v = scr_q;
    endcase
    return v;
  endfunction

  function automatic void bus_write(reg_addr_t a, logic [7:0] d);
    bit en_changed;
    case (a)
      REG_DATA: begin
        if (lcr_q[DLAB_BIT]) begin
          divisor[7:0] = d;
        end else if (tx_count < fifo_capacity()) begin
          tx_fifo[(tx_head + tx_count) % DEPTH] = d;
          tx_count++;
        end
      end
      REG_IER: begin
        if (lcr_q[DLAB_BIT]) divisor[15:8] = d;
        else ier_q = {4'h0, d[3:0]};
      end
      // fcr shares the iir offset
      REG_IIR: begin
        en_changed = (d[0] != fifo_on);
        if (en_changed || (d[0] && d[1])) begin
          rx_used = 0;
          rx_head = 0;
        end
        if (en_changed || (d[0] && d[2])) begin
          tx_count = 0;
          tx_head = 0;
        end
        fifo_on = d[0];
      end
      REG_LCR: lcr_q = d;
      REG_MCR: mcr_q = {3'b000, d[4:0]};
      REG_SCR: scr_q = d;
      default: ;
    endcase
  endfunction

  function automatic out_item_t uart_event_response(in_item_t it);
    out_item_t r;
    r = '0;
    if (it.cts_in != cts_q) delta_cts = 1'b1;
    if (it.dsr_in != dsr_q) delta_dsr = 1'b1;
    cts_q = it.cts_in;
    dsr_q = it.dsr_in;
    case (it.opcode)
      OP_BUS_READ: r.read_data = bus_read(it.reg_addr);
      OP_BUS_WRITE: bus_write(it.reg_addr, it.write_data);
      OP_LINE_RX: begin
        if (rx_used >= fifo_capacity()) begin
          overrun = 1'b1;
        end else begin
          rx_fifo[(rx_head + rx_used) % DEPTH] =
            {it.rx_break, it.rx_framing_error, it.rx_parity_error, it.rx_byte};
          rx_used++;
        end
      end
      default: begin
        if (tx_count > 0) begin
          r.tx_valid = 1'b1;
          r.tx_byte = tx_fifo[tx_head];
          tx_head = (tx_head + 1) % DEPTH;
          tx_count--;
        end
      end
    endcase
    r.irq = mcr_q[OUT2_BIT] && (pending_irq_id() != IIR_NONE);
    r.rts_out = mcr_q[1];
    r.dtr_out = mcr_q[0];
    r.baud_divisor = divisor;
    return r;
  endfunction

  function automatic int pick_wait();
    if (steady_flow || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic in_item_t base_event(opcode_t op);
    in_item_t it;
    it.opcode = op;
    it.reg_addr = reg_addr_t'($urandom_range(0, 7));
    it.write_data = 8'($urandom_range(0, 255));
    it.rx_byte = 8'($urandom_range(0, 255));
    it.rx_parity_error = 1'($urandom_range(0, 1));
    it.rx_framing_error = 1'($urandom_range(0, 1));
    it.rx_break = 1'($urandom_range(0, 1));
    it.cts_in = line_cts;
    it.dsr_in = line_dsr;
    return it;
  endfunction

  task automatic send_event(in_item_t it);
    int gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk); while (!in_if.ready);
    uart_response_q.push_back(uart_event_response(it));
  endtask

  task automatic bus_rd(reg_addr_t a);
    in_item_t it;
    it = base_event(OP_BUS_READ);
    it.reg_addr = a;
    send_event(it);
  endtask

  task automatic bus_wr(reg_addr_t a, logic [7:0] d);
    in_item_t it;
    it = base_event(OP_BUS_WRITE);
    it.reg_addr = a;
    it.write_data = d;
    send_event(it);
  endtask

  task automatic line_rx(logic [7:0] b, logic pe, logic fe, logic brk);
    in_item_t it;
    it = base_event(OP_LINE_RX);
    it.rx_byte = b;
    it.rx_parity_error = pe;
    it.rx_framing_error = fe;
    it.rx_break = brk;
    send_event(it);
  endtask

  task automatic line_tx();
    send_event(base_event(OP_LINE_TX));
  endtask

  task automatic wait_for_responses();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (uart_response_q.size() > 0) @(posedge clk);
  endtask

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t %s mismatch: expected %h, got %h", $time, name, want, got);
    end
  endfunction

  task automatic check_response(out_item_t got);
    out_item_t want;
    if (uart_response_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t result transfer with nothing pending, payload %h", $time, got);
      return;
    end
    want = uart_response_q.pop_front();
    compare_field("read_data", 16'(want.read_data), 16'(got.read_data));
    compare_field("tx_valid", 16'(want.tx_valid), 16'(got.tx_valid));
    compare_field("tx_byte", 16'(want.tx_byte), 16'(got.tx_byte));
    compare_field("irq", 16'(want.irq), 16'(got.irq));
    compare_field("rts_out", 16'(want.rts_out), 16'(got.rts_out));
    compare_field("dtr_out", 16'(want.dtr_out), 16'(got.dtr_out));
    compare_field("baud_divisor", want.baud_divisor, got.baud_divisor);
  endtask

  // result side: random stalls, one check per transfer
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = pick_wait();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      check_response(out_if.data);
    end
  end

  task automatic test_register_readback();
    bus_wr(REG_SCR, 8'hFF);
    bus_rd(REG_SCR);
    bus_wr(REG_IER, 8'hFF);
    bus_rd(REG_IER);
    bus_wr(REG_MCR, 8'hFF);
  endtask

  task automatic test_divisor_latch();
    bus_wr(REG_LCR, 8'hFF);
    bus_wr(REG_DATA, 8'hFF);
    bus_wr(REG_IER, 8'hFF);
    bus_rd(REG_DATA);
    bus_rd(REG_IER);
    bus_wr(REG_LCR, 8'h00);
  endtask

  // fifo mode off: single holding register each way
  task automatic test_holding_registers();
    line_rx(8'hFF, 1'b1, 1'b1, 1'b1);
    line_rx(8'h00, 1'b0, 1'b0, 1'b0);
    bus_rd(REG_IIR);
    bus_rd(REG_LSR);
    bus_rd(REG_DATA);
    bus_rd(REG_DATA);
    bus_wr(REG_DATA, 8'h00);
    bus_wr(REG_DATA, 8'hA5);
    line_tx();
    line_tx();
  endtask

  task automatic test_fifo_control();
    bus_wr(REG_IIR, 8'h07);
    bus_rd(REG_IIR);
    bus_wr(REG_IIR, 8'h00);
  endtask

  task automatic test_modem_status();
    line_cts = 1'b1;
    line_dsr = 1'b1;
    bus_rd(REG_MSR);
    bus_rd(REG_MSR);
    bus_wr(REG_LSR, 8'hFF);
    bus_wr(REG_MSR, 8'hFF);
  endtask

  task automatic test_random_traffic(int total);
    int        sent;
    int        burst;
    int        profile;
    int        rx_w;
    int        tx_w;
    int        pick;
    reg_addr_t a;
    logic [7:0] d;
    sent = 0;
    while (sent < total) begin
      burst = $urandom_range(40, 120);
      profile = $urandom_range(0, 3);
      steady_flow = ($urandom_range(0, 3) == 0);
      case (profile)
        0: begin
          rx_w = 55;
          tx_w = 5;
        end
        1: begin
          rx_w = 5;
          tx_w = 10;
        end
        2: begin
          rx_w = 25;
          tx_w = 25;
        end
        default: begin
          rx_w = 5;
          tx_w = 5;
        end
      endcase
      repeat (burst) begin
        if ($urandom_range(0, 19) == 0) line_cts = ~line_cts;
        if ($urandom_range(0, 19) == 0) line_dsr = ~line_dsr;
        pick = $urandom_range(0, 99);
        if (pick < rx_w) begin
          line_rx(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0,
                  $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0);
        end else if (pick < rx_w + tx_w) begin
          line_tx();
        end else begin
          a = ($urandom_range(0, 9) < 4) ? REG_DATA : reg_addr_t'($urandom_range(0, 7));
          d = 8'($urandom_range(0, 255));
          // keep dlab mostly clear so data accesses reach the fifos
          if (a == REG_LCR && $urandom_range(0, 7) != 0) d[DLAB_BIT] = 1'b0;
          if (a == REG_IIR) begin
            d[0] = ($urandom_range(0, 7) != 0);
            d[1] = ($urandom_range(0, 7) == 0);
            d[2] = ($urandom_range(0, 7) == 0);
          end
          if ($urandom_range(0, 99) < (profile == 1 ? 75 : 50)) bus_wr(a, d);
          else bus_rd(a);
        end
        sent++;
      end
      steady_flow = 1'b0;
      if ($urandom_range(0, 7) == 0) wait_for_responses();
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    clear_uart_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_readback();
    test_divisor_latch();
    test_holding_registers();
    test_fifo_control();
    test_modem_status();
    wait_for_responses();
    test_random_traffic(RANDOM_ITEMS);
    wait_for_responses();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && uart_response_q.size() == 0) begin
      $display("uart_16550_register_block verification clean");
    end else begin
      $display("uart_16550_register_block verification failed");
    end
    $finish;
  end

endmodule
